// File: design/sor_pkg.sv
// Shared types, constants and binary32 helpers for the sphere overlap test.
// No dependencies; used by sor_fadd, sor_fmul and the top level.
`default_nettype none
package sor_pkg;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic [31:0] radius_a;
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] bz;
		logic [31:0] radius_b;
	} pair_t;

	typedef struct packed {
		logic hit;
		logic overflowed;
	} result_t;

	localparam logic [31:0] MAGIC_RSQRT = 32'h5f3759df;
	localparam logic [31:0] POS_INF     = 32'h7f800000;
	localparam logic [31:0] QNAN        = 32'h7fc00000;
	localparam logic [31:0] FP_ONE      = 32'h3f800000;
	localparam logic [31:0] FP_HALF     = 32'h3f000000;
	localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;

	// Count leading zeros of a 51-bit mantissa (nonzero input expected)
	function automatic logic [5:0] lzc51(input logic [50:0] m);
		logic [5:0] n;
		begin
			n = 6'd51;
			for (int i = 0; i < 51; i++) begin
				if (m[i]) n = 6'(50 - i);
			end
			return n;
		end
	endfunction

	// Round to nearest even and pack; m has its leading one at bit 50,
	// be is the biased exponent of that bit.
	function automatic logic [31:0] fp_round(input logic sgn, input logic [50:0] m,
		input logic signed [11:0] be);
		logic [5:0] sh;
		logic [101:0] wide;
		logic [50:0] mm;
		logic st;
		logic [7:0] ef;
		logic rnd;
		begin
			if (be > 12'sd254) return {sgn, 8'hff, 23'd0};
			if (be < 12'sd1) begin
				if (be < -12'sd50) sh = 6'd51;
				else sh = 6'(12'sd1 - be);
				ef = 8'd0;
			end else begin
				sh = 6'd0;
				ef = be[7:0];
			end
			wide = {m, 51'd0} >> sh;
			mm = wide[101:51];
			st = |wide[50:0];
			rnd = mm[26] & (st | (|mm[25:0]) | mm[27]);
			// a carry out of the fraction bumps the exponent, up to infinity
			return {sgn, ef, mm[49:27]} + {31'd0, rnd};
		end
	endfunction

endpackage
`default_nettype wire

// File: design/sor_fadd.sv
// Binary32 adder, round to nearest even, full subnormal and special handling.
// Depends on sor_pkg (fp_round, lzc51, QNAN, POS_INF).
`default_nettype none
module sor_fadd
	import sor_pkg::*;
(
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic [31:0]      sum
);

	logic [31:0] big, lit;
	logic a_nan, b_nan, a_inf, b_inf;
	logic [7:0] eb_e, el_e, d;
	logic [50:0] mb, ml, ml_sh, raw;
	logic [101:0] ml_wide;
	logic sticky;
	logic [5:0] lz;
	logic signed [11:0] be;

	// Classify operands
	assign a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
	assign a_inf = (a[30:0] == POS_INF[30:0]);
	assign b_inf = (b[30:0] == POS_INF[30:0]);

	// Order by magnitude and align the smaller operand
	always_comb begin
		if (b[30:0] > a[30:0]) begin
			big = b;
			lit = a;
		end else begin
			big = a;
			lit = b;
		end
		eb_e = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		el_e = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
		d = eb_e - el_e;
		mb = {1'b0, (big[30:23] != 8'd0), big[22:0], 26'd0};
		ml = {1'b0, (lit[30:23] != 8'd0), lit[22:0], 26'd0};
		ml_wide = {ml, 51'd0} >> ((d > 8'd51) ? 8'd51 : d);
		sticky = |ml_wide[50:0];
		ml_sh = ml_wide[101:51] | {50'd0, sticky};
		if (big[31] == lit[31]) raw = mb + ml_sh;
		else raw = mb - ml_sh;
		lz = lzc51(raw);
		be = $signed({4'd0, eb_e}) + 12'sd1 - $signed({6'd0, lz});
	end

	// Select specials, exact zero, or the rounded sum
	always_comb begin
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) sum = QNAN;
		else if (a_inf) sum = a;
		else if (b_inf) sum = b;
		else if (raw == 51'd0) sum = {a[31] & b[31], 31'd0};
		else sum = fp_round(big[31], raw << lz, be);
	end

endmodule
`default_nettype wire

// File: design/sor_fmul.sv
// Binary32 multiplier, round to nearest even, full subnormal and special handling.
// Depends on sor_pkg (fp_round, lzc51, QNAN, POS_INF).
`default_nettype none
module sor_fmul
	import sor_pkg::*;
(
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic [31:0]      prod
);

	logic sgn;
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [47:0] p;
	logic [50:0] raw;
	logic [5:0] lz;
	logic [7:0] ea_e, eb_e;
	logic signed [11:0] be;

	assign sgn    = a[31] ^ b[31];
	assign a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
	assign a_inf  = (a[30:0] == POS_INF[30:0]);
	assign b_inf  = (b[30:0] == POS_INF[30:0]);
	assign a_zero = (a[30:0] == 31'd0);
	assign b_zero = (b[30:0] == 31'd0);

	// Form the significand product and its exponent
	always_comb begin
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		ea_e = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb_e = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		p = ma * mb;
		raw = {p, 3'd0};
		lz = lzc51(raw);
		be = $signed({4'd0, ea_e}) + $signed({4'd0, eb_e}) - 12'sd126
			- $signed({6'd0, lz});
	end

	// Select specials, signed zero, or the rounded product
	always_comb begin
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) prod = QNAN;
		else if (a_inf || b_inf) prod = {sgn, POS_INF[30:0]};
		else if (a_zero || b_zero) prod = {sgn, 31'd0};
		else prod = fp_round(sgn, raw << lz, be);
	end

endmodule
`default_nettype wire

// File: design/sphere_overlap_rsqrt_test.sv
// Sphere overlap test: pipelined binary32 distance, fast inverse sqrt, compare.
// Depends on sor_pkg, sor_fadd and sor_fmul.
//
//  channel   signals                       word
//  in        pair_valid, pair_stall        pair   (two spheres, binary32 bits)
//  out       result_valid, result_stall    result (hit, overflowed)
//
// Eleven register stages; stages 1 to 10 add or multiply, stage 11 compares.
// A new word is taken every cycle while pair_stall is low.
// Reset clears the stage valid bits only; data registers are not reset.
// Each stage holds when it is full and the stage after it cannot take its word,
// so bubbles close up and a stall loses or repeats nothing.
`default_nettype none
module sphere_overlap_rsqrt_test
	import sor_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pair_valid,
	output logic         pair_stall,
	input  wire pair_t   pair,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int NSTG = 11;

	logic [NSTG:1] vld;
	logic [NSTG:1] adv;
	logic [NSTG:0] vin;

	// Stage data
	logic [31:0] dx_s1, dy_s1, dz_s1, rsum_s1;
	logic [31:0] px_s2, py_s2, pz_s2, rsum_s2;
	logic [31:0] sxy_s3, pz_s3, rsum_s3;
	logic [31:0] s_s4, rsum_s4;
	logic [31:0] half_s5, y0_s5, rsum_s5;
	logic [31:0] t1_s6, y0_s6, rsum_s6;
	logic [31:0] t2_s7, y0_s7, rsum_s7;
	logic [31:0] t3_s8, y0_s8, rsum_s8;
	logic [31:0] r_s9, rsum_s9;
	logic [31:0] prod_s10;
	logic ovf_s5, ovf_s6, ovf_s7, ovf_s8, ovf_s9, ovf_s10;
	result_t res_s11;

	// Combinational results of the arithmetic units
	logic [31:0] dx_c, dy_c, dz_c, rsum_c;
	logic [31:0] px_c, py_c, pz_c, sxy_c, s_c;
	logic [31:0] half_c, t1_c, t2_c, t3_c, r_c, prod_c;
	logic hit_c;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		adv[NSTG] = !vld[NSTG] || !result_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k + 1];
		end
	end

	assign vin = {vld, pair_valid};
	assign pair_stall = !adv[1];
	assign result_valid = vld[NSTG];
	assign result = res_s11;

	// Move valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (adv[k]) vld[k] <= vin[k - 1];
			end
		end
	end

	// Stage 1: coordinate differences and radius sum
	sor_fadd u_dx (.a(pair.ax), .b({~pair.bx[31], pair.bx[30:0]}), .sum(dx_c));
	sor_fadd u_dy (.a(pair.ay), .b({~pair.by[31], pair.by[30:0]}), .sum(dy_c));
	sor_fadd u_dz (.a(pair.az), .b({~pair.bz[31], pair.bz[30:0]}), .sum(dz_c));
	sor_fadd u_rs (.a(pair.radius_a), .b(pair.radius_b), .sum(rsum_c));

	// Stage 2: squares
	sor_fmul u_px (.a(dx_s1), .b(dx_s1), .prod(px_c));
	sor_fmul u_py (.a(dy_s1), .b(dy_s1), .prod(py_c));
	sor_fmul u_pz (.a(dz_s1), .b(dz_s1), .prod(pz_c));

	// Stages 3 and 4: squared distance, x and y first
	sor_fadd u_sxy (.a(px_s2), .b(py_s2), .sum(sxy_c));
	sor_fadd u_s   (.a(sxy_s3), .b(pz_s3), .sum(s_c));

	// Stages 5 to 9: bit trick estimate and one Newton step
	sor_fmul u_half (.a(s_s4), .b(FP_HALF), .prod(half_c));
	sor_fmul u_t1   (.a(half_s5), .b(y0_s5), .prod(t1_c));
	sor_fmul u_t2   (.a(t1_s6), .b(y0_s6), .prod(t2_c));
	sor_fadd u_t3   (.a(FP_THREE_HALVES), .b({~t2_s7[31], t2_s7[30:0]}), .sum(t3_c));
	sor_fmul u_r    (.a(y0_s8), .b(t3_s8), .prod(r_c));

	// Stage 10: scale by radius sum
	sor_fmul u_prod (.a(r_s9), .b(rsum_s9), .prod(prod_c));

	// Greater than one: positive, above one's pattern, not NaN, no overflow flag
	assign hit_c = !prod_s10[31] && (prod_s10[30:0] > FP_ONE[30:0])
		&& (prod_s10[30:0] <= POS_INF[30:0]) && !ovf_s10;

	// Load stage data on advance
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			dz_s1 <= dz_c;
			rsum_s1 <= rsum_c;
		end
		if (adv[2]) begin
			px_s2 <= px_c;
			py_s2 <= py_c;
			pz_s2 <= pz_c;
			rsum_s2 <= rsum_s1;
		end
		if (adv[3]) begin
			sxy_s3 <= sxy_c;
			pz_s3 <= pz_s2;
			rsum_s3 <= rsum_s2;
		end
		if (adv[4]) begin
			s_s4 <= s_c;
			rsum_s4 <= rsum_s3;
		end
		if (adv[5]) begin
			half_s5 <= half_c;
			y0_s5 <= MAGIC_RSQRT - {1'b0, s_s4[31:1]};
			ovf_s5 <= (s_s4 == POS_INF);
			rsum_s5 <= rsum_s4;
		end
		if (adv[6]) begin
			t1_s6 <= t1_c;
			y0_s6 <= y0_s5;
			ovf_s6 <= ovf_s5;
			rsum_s6 <= rsum_s5;
		end
		if (adv[7]) begin
			t2_s7 <= t2_c;
			y0_s7 <= y0_s6;
			ovf_s7 <= ovf_s6;
			rsum_s7 <= rsum_s6;
		end
		if (adv[8]) begin
			t3_s8 <= t3_c;
			y0_s8 <= y0_s7;
			ovf_s8 <= ovf_s7;
			rsum_s8 <= rsum_s7;
		end
		if (adv[9]) begin
			r_s9 <= r_c;
			ovf_s9 <= ovf_s8;
			rsum_s9 <= rsum_s8;
		end
		if (adv[10]) begin
			prod_s10 <= prod_c;
			ovf_s10 <= ovf_s9;
		end
		if (adv[11]) begin
			res_s11.hit <= hit_c;
			res_s11.overflowed <= ovf_s10;
		end
	end

endmodule
`default_nettype wire
